@@ rtl/asr_pkg.sv @@
`default_nettype none
package asr_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned CosW   = 16;
    localparam int unsigned IdxW   = 3;
    localparam int unsigned NumAx  = 3;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [CosW-1:0]   t_cos;
    typedef logic signed [2*CosW-1:0] t_prod;
    typedef logic [CosW:0]            t_mag;

    localparam t_coord CoordMax = {1'b0, {(CoordW-1){1'b1}}};
    localparam t_coord CoordMin = {1'b1, {(CoordW-1){1'b0}}};

    localparam t_cos CosOne  = {1'b0, {(CosW-1){1'b1}}};
    localparam t_cos CosZero = '0;

    // register indexes of the configuration port
    localparam logic [IdxW-1:0] RegRowX = 3'd0;
    localparam logic [IdxW-1:0] RegRowY = 3'd1;
    localparam logic [IdxW-1:0] RegRowZ = 3'd2;
    localparam logic [IdxW-1:0] RegColX = 3'd3;
    localparam logic [IdxW-1:0] RegColY = 3'd4;
    localparam logic [IdxW-1:0] RegColZ = 3'd5;

    // axis codes
    localparam logic [1:0] ColX = 2'd0;
    localparam logic [1:0] ColY = 2'd1;
    localparam logic [1:0] ColZ = 2'd2;

    typedef struct packed {
        logic [NumAx-1:0][1:0] col;
        logic [NumAx-1:0]      neg;
    } t_perm;

    function automatic t_mag mag(input logic [CosW-1:0] v);
        logic signed [CosW:0] ext;
        ext = {v[CosW-1], v};
        return ext[CosW] ? t_mag'(-ext) : t_mag'(ext);
    endfunction

    // first maximum among the columns not excluded
    function automatic logic [1:0] pick(input logic [NumAx-1:0][CosW:0] m,
                                        input logic [NumAx-1:0] ex);
        logic [1:0] best;
        t_mag       bv;
        logic       found;
        best  = ColX;
        bv    = '0;
        found = 1'b0;
        for (int j = 0; j < NumAx; j++) begin
            if (!ex[j] && (!found || m[j] > bv)) begin
                found = 1'b1;
                bv    = m[j];
                best  = 2'(j);
            end
        end
        return best;
    endfunction

    function automatic t_coord neg_sat(input t_coord v);
        return (v == CoordMin) ? CoordMax : -v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/asr_in_if.sv @@
`default_nettype none
interface asr_in_if;
    import asr_pkg::*;

    logic   valid;
    logic   ready;
    t_coord coord_x;
    t_coord coord_y;
    t_coord coord_z;
    logic   make_absolute;
    logic   inverse;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    output make_absolute, output inverse, input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    input make_absolute, input inverse, output ready);
endinterface
`default_nettype wire

@@ rtl/asr_out_if.sv @@
`default_nettype none
interface asr_out_if;
    import asr_pkg::*;

    logic   valid;
    logic   ready;
    t_coord out_x;
    t_coord out_y;
    t_coord out_z;

    modport source (output valid, output out_x, output out_y, output out_z, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface
`default_nettype wire

@@ rtl/asr_snap.sv @@
`default_nettype none
module asr_snap (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [asr_pkg::IdxW-1:0] i_cfg_idx,
    input  logic [asr_pkg::CosW-1:0] i_cfg_data,
    output asr_pkg::t_perm           o_perm
);
    import asr_pkg::*;

    localparam t_prod ProdOne = t_prod'(int'(CosOne) * int'(CosOne));

    t_cos r_rx, r_ry, r_rz, r_cx, r_cy, r_cz;

    // stage a: cross product terms, rows 0 and 1 chosen
    t_prod r_pyz, r_pzy, r_pzx, r_pxz, r_pxy, r_pyx;
    logic [1:0] r_k0, r_k1, n_k0, n_k1;
    logic       r_s0, r_s1, n_s0, n_s1;

    // stage b: row 2 and final map
    t_perm      r_perm, n_perm;
    logic [1:0] w_k2;
    logic       w_s2;

    logic [NumAx-1:0][CosW-1:0] w_r0, w_r1;
    logic [NumAx-1:0][CosW:0]   w_m0, w_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx <= CosOne;
            r_ry <= CosZero;
            r_rz <= CosZero;
            r_cx <= CosZero;
            r_cy <= CosOne;
            r_cz <= CosZero;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegRowX: r_rx <= i_cfg_data;
                RegRowY: r_ry <= i_cfg_data;
                RegRowZ: r_rz <= i_cfg_data;
                RegColX: r_cx <= i_cfg_data;
                RegColY: r_cy <= i_cfg_data;
                RegColZ: r_cz <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_r0 = {r_rz, r_ry, r_rx};
        w_r1 = {r_cz, r_cy, r_cx};
        for (int j = 0; j < NumAx; j++) begin
            w_m0[j] = mag(w_r0[j]);
            w_m1[j] = mag(w_r1[j]);
        end
        n_k0 = pick(w_m0, 3'b000);
        n_k1 = pick(w_m1, 3'b001 << n_k0);
        n_s0 = w_r0[n_k0][CosW-1];
        n_s1 = w_r1[n_k1][CosW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pyz <= '0;
            r_pzy <= '0;
            r_pzx <= '0;
            r_pxz <= '0;
            r_pxy <= ProdOne;
            r_pyx <= '0;
            r_k0  <= ColX;
            r_k1  <= ColY;
            r_s0  <= 1'b0;
            r_s1  <= 1'b0;
        end else begin
            r_pyz <= t_prod'(r_ry) * t_prod'(r_cz);
            r_pzy <= t_prod'(r_rz) * t_prod'(r_cy);
            r_pzx <= t_prod'(r_rz) * t_prod'(r_cx);
            r_pxz <= t_prod'(r_rx) * t_prod'(r_cz);
            r_pxy <= t_prod'(r_rx) * t_prod'(r_cy);
            r_pyx <= t_prod'(r_ry) * t_prod'(r_cx);
            r_k0  <= n_k0;
            r_k1  <= n_k1;
            r_s0  <= n_s0;
            r_s1  <= n_s1;
        end
    end

    // the last row takes the one column left
    always_comb begin
        w_k2 = 2'd3 - r_k0 - r_k1;
        case (w_k2)
            ColX:    w_s2 = r_pyz < r_pzy;
            ColY:    w_s2 = r_pzx < r_pxz;
            default: w_s2 = r_pxy < r_pyx;
        endcase
        n_perm.col = {w_k2, r_k1, r_k0};
        n_perm.neg = {w_s2, r_s1, r_s0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm.col <= {ColZ, ColY, ColX};
            r_perm.neg <= '0;
        end else begin
            r_perm <= n_perm;
        end
    end

    assign o_perm = r_perm;

    a_rows_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k0 != r_k1)
        else $error("rows 0 and 1 share a column");

    a_perm_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_perm.col[0] != r_perm.col[1] && r_perm.col[0] != r_perm.col[2] &&
        r_perm.col[1] != r_perm.col[2] && r_perm.col[2] != 2'd3)
        else $error("snapped map is not a permutation");

endmodule
`default_nettype wire

@@ rtl/asr_map.sv @@
`default_nettype none
module asr_map (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  asr_pkg::t_perm i_perm,
    asr_in_if.sink         i_in,
    asr_out_if.source      o_out
);
    import asr_pkg::*;

    logic r_run;

    // stage 1: captured word
    logic   r_v1;
    t_coord r_c1 [NumAx];
    logic   r_abs1, r_inv1;

    // stage 2: plain, negated and absolute forms
    logic   r_v2;
    t_coord r_c2 [NumAx];
    t_coord r_n2 [NumAx];
    t_coord r_a2 [NumAx];
    logic   r_abs2, r_inv2;

    // stage 3: output register
    logic   r_v3;
    t_coord r_o3 [NumAx];
    t_coord n_o3 [NumAx];

    logic w_rdy1, w_rdy2, w_rdy3;

    assign w_rdy3 = !r_v3 || o_out.ready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign i_in.ready = r_run && w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (w_rdy1) begin
                r_v1 <= i_in.valid && r_run;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_c1[0] <= i_in.coord_x;
            r_c1[1] <= i_in.coord_y;
            r_c1[2] <= i_in.coord_z;
            r_abs1  <= i_in.make_absolute;
            r_inv1  <= i_in.inverse;
        end
        if (w_rdy2) begin
            for (int i = 0; i < NumAx; i++) begin
                r_c2[i] <= r_c1[i];
                r_n2[i] <= neg_sat(r_c1[i]);
                r_a2[i] <= r_c1[i][CoordW-1] ? neg_sat(r_c1[i]) : r_c1[i];
            end
            r_abs2 <= r_abs1;
            r_inv2 <= r_inv1;
        end
        if (w_rdy3) begin
            r_o3 <= n_o3;
        end
    end

    always_comb begin
        for (int i = 0; i < NumAx; i++) begin
            n_o3[i] = '0;
        end
        for (int i = 0; i < NumAx; i++) begin
            if (r_inv2) begin
                n_o3[i] = i_perm.neg[i] ? r_n2[i_perm.col[i]] : r_c2[i_perm.col[i]];
            end else if (r_abs2) begin
                n_o3[i_perm.col[i]] = r_a2[i];
            end else begin
                n_o3[i_perm.col[i]] = i_perm.neg[i] ? r_n2[i] : r_c2[i];
            end
        end
    end

    assign o_out.valid = r_v3;
    assign o_out.out_x = r_o3[0];
    assign o_out.out_y = r_o3[1];
    assign o_out.out_z = r_o3[2];

    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !w_rdy3 |=> r_v2 && $stable(r_c2[0]) && $stable(r_inv2))
        else $error("stage 2 word lost under stall");

    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !w_rdy2 |=> r_v1 && $stable(r_c1[1]) && $stable(r_abs1))
        else $error("stage 1 word lost under stall");

endmodule
`default_nettype wire

@@ rtl/axis_snap_reorient_unit.sv @@
// channel   dir  handshake      payload
// i_in      in   valid/ready    coord_x, coord_y, coord_z, make_absolute, inverse
// o_out     out  valid/ready    out_x, out_y, out_z
// i_cfg_*   in   write enable   index 0..5, 16-bit direction cosine
//
// one word per cycle sustained while o_out is ready; three word registers, and a word
// taken from i_in passes through stages 1, 2 and 3 in that order to o_out
// the map is rebuilt in two register stages after a write, ahead of the third word stage
// reset is synchronous, active low; i_in.ready stays low in reset and until r_run is set
// a stall on o_out backs up through the three word registers, nothing dropped or repeated
`default_nettype none
module axis_snap_reorient_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [asr_pkg::IdxW-1:0] i_cfg_idx,
    input  logic [asr_pkg::CosW-1:0] i_cfg_data,
    asr_in_if.sink                   i_in,
    asr_out_if.source                o_out
);
    import asr_pkg::*;

    t_perm w_perm;

    asr_snap u_snap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_perm     (w_perm)
    );

    asr_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_perm  (w_perm),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

@@ sim/tb_axis_snap_reorient_unit.sv @@
`timescale 1ns / 1ps

module tb_axis_snap_reorient_unit;
    import asr_pkg::*;

    localparam int QuietLimit  = 2000;
    localparam int DrainCycles = 8;

    // indexes beyond the six cosine registers, written to check they are ignored
    localparam logic [IdxW-1:0] RegSpareLo = 3'd6;
    localparam logic [IdxW-1:0] RegSpareHi = 3'd7;

    localparam t_cos CosNegOne = 16'sh8000;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_xyz;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [IdxW-1:0]     i_cfg_idx;
    logic [CosW-1:0]     i_cfg_data;

    asr_in_if  in_if ();
    asr_out_if out_if ();

    axis_snap_reorient_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    t_cos       row_dir [3];
    t_cos       col_dir [3];
    logic [1:0] axis_of [3];
    bit         flip    [3];

    t_xyz pending [$];

    bit gap_on;
    bit stall_on;
    int stall_left;
    int quiet;
    int errors;
    int n_checked;
    int n_fwd;
    int n_abs;
    int n_inv;
    int n_orient;

    always #10 i_clk = ~i_clk;

    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(99);
        if (!enabled || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // nearest signed axis per row of the cosine matrix, third row from the cross product
    function automatic void refresh_map();
        longint m [3][3];
        bit     taken [3];
        longint top;
        longint amp;
        int     best;
        for (int j = 0; j < 3; j++) begin
            m[0][j]  = longint'(row_dir[j]);
            m[1][j]  = longint'(col_dir[j]);
            taken[j] = 1'b0;
        end
        m[2][0] = longint'(row_dir[1]) * longint'(col_dir[2])
                - longint'(row_dir[2]) * longint'(col_dir[1]);
        m[2][1] = longint'(row_dir[2]) * longint'(col_dir[0])
                - longint'(row_dir[0]) * longint'(col_dir[2]);
        m[2][2] = longint'(row_dir[0]) * longint'(col_dir[1])
                - longint'(row_dir[1]) * longint'(col_dir[0]);
        for (int i = 0; i < 3; i++) begin
            top  = -1;
            best = 0;
            for (int j = 0; j < 3; j++) begin
                amp = (m[i][j] < 0) ? -m[i][j] : m[i][j];
                if (!taken[j] && amp > top) begin
                    top  = amp;
                    best = j;
                end
            end
            taken[best] = 1'b1;
            axis_of[i]  = 2'(best);
            flip[i]     = m[i][best] < 0;
        end
    endfunction

    function automatic t_coord negate_sat(input t_coord a);
        longint v;
        v = -longint'(a);
        return (v > longint'(CoordMax)) ? CoordMax : t_coord'(v);
    endfunction

    function automatic t_xyz reorient(input t_coord x, input t_coord y, input t_coord z,
                                      input logic absf, input logic invf);
        t_coord c [3];
        t_coord r [3];
        t_xyz   w;
        c[0] = x;
        c[1] = y;
        c[2] = z;
        for (int i = 0; i < 3; i++) r[i] = '0;
        for (int i = 0; i < 3; i++) begin
            if (invf)
                r[i] = flip[i] ? negate_sat(c[axis_of[i]]) : c[axis_of[i]];
            else
                r[axis_of[i]] = flip[i] ? negate_sat(c[i]) : c[i];
        end
        if (absf && !invf) begin
            for (int i = 0; i < 3; i++) begin
                if (r[i] < 0) r[i] = negate_sat(r[i]);
            end
        end
        w.x = r[0];
        w.y = r[1];
        w.z = r[2];
        return w;
    endfunction

    function automatic t_coord rand_coord();
        int r;
        r = $urandom_range(9);
        if (r < 6) return t_coord'($urandom);
        if (r < 8) begin
            case ($urandom_range(5))
                0: return CoordMin;
                1: return CoordMax;
                2: return '0;
                3: return -1;
                4: return 1;
                default: return CoordMin + 1;
            endcase
        end
        return t_coord'($urandom_range(0, 200) - 100);
    endfunction

    function automatic void compare_field(input string name, input t_coord want,
                                          input t_coord got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            errors++;
        end
    endfunction

    task automatic send_word(input t_coord x, input t_coord y, input t_coord z,
                             input logic absf, input logic invf);
        int gap;
        gap = pick_gap(gap_on);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.coord_x       <= x;
        in_if.coord_y       <= y;
        in_if.coord_z       <= z;
        in_if.make_absolute <= absf;
        in_if.inverse       <= invf;
        do @(posedge i_clk); while (!in_if.ready);
        pending.push_back(reorient(x, y, z, absf, invf));
        if (invf) n_inv++;
        else n_fwd++;
        if (absf && !invf) n_abs++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IdxW-1:0] idx, input t_cos data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            RegRowX: row_dir[0] = data;
            RegRowY: row_dir[1] = data;
            RegRowZ: row_dir[2] = data;
            RegColX: col_dir[0] = data;
            RegColY: col_dir[1] = data;
            RegColZ: col_dir[2] = data;
            default: ;
        endcase
    endtask

    task automatic set_orientation(input t_cos rx, input t_cos ry, input t_cos rz,
                                   input t_cos cx, input t_cos cy, input t_cos cz,
                                   input bit with_spare);
        drain();
        write_reg(RegRowX, rx);
        write_reg(RegRowY, ry);
        write_reg(RegRowZ, rz);
        write_reg(RegColX, cx);
        write_reg(RegColY, cy);
        write_reg(RegColZ, cz);
        if (with_spare) begin
            write_reg(RegSpareLo, t_cos'($urandom));
            write_reg(RegSpareHi, t_cos'($urandom));
        end
        i_cfg_we <= 1'b0;
        refresh_map();
        n_orient++;
    endtask

    task automatic send_corner_words();
        send_word(CoordMin, CoordMax, -1, 1'b0, 1'b0);
        send_word(CoordMax, CoordMin, '0, 1'b1, 1'b0);
        send_word(-1, 1, CoordMin, 1'b1, 1'b1);
        send_word(CoordMin, CoordMin, CoordMin, 1'b0, 1'b1);
    endtask

    task automatic test_reset_orientation();
        send_corner_words();
    endtask

    task automatic test_swapped_negated_axes();
        set_orientation(CosZero, CosZero, CosNegOne, CosNegOne, CosZero, CosZero, 1'b0);
        send_corner_words();
    endtask

    task automatic test_first_max_ties();
        set_orientation(16'sd20000, -16'sd20000, 16'sd20000,
                        -16'sd5000, -16'sd5000, 16'sd5000, 1'b0);
        send_corner_words();
    endtask

    task automatic test_zero_cosines();
        set_orientation(CosZero, CosZero, CosZero, CosZero, CosZero, CosZero, 1'b0);
        send_corner_words();
    endtask

    task automatic test_taken_column_skip();
        set_orientation(CosOne, CosZero, CosZero, CosOne, 16'sd100, -16'sd200, 1'b0);
        send_corner_words();
    endtask

    task automatic test_unused_index();
        set_orientation(CosZero, CosOne, CosZero, CosZero, CosZero, CosNegOne, 1'b1);
        send_corner_words();
    endtask

    task automatic load_random_orientation();
        t_cos v [6];
        t_cos amp;
        int   a;
        int   b;
        case ($urandom_range(3))
            0: for (int i = 0; i < 6; i++) v[i] = t_cos'($urandom);
            1: begin
                for (int i = 0; i < 6; i++) begin
                    case ($urandom_range(4))
                        0: v[i] = CosNegOne;
                        1: v[i] = CosOne;
                        2: v[i] = CosZero;
                        3: v[i] = -16'sd1;
                        default: v[i] = 16'sd1;
                    endcase
                end
            end
            2: begin
                // near-orthonormal frame with small off-axis noise
                for (int i = 0; i < 6; i++) v[i] = t_cos'($urandom_range(0, 6000) - 3000);
                a = $urandom_range(2);
                b = (a + 1 + $urandom_range(1)) % 3;
                v[a]     = t_cos'($urandom_range(28000, 32767));
                v[3 + b] = t_cos'($urandom_range(28000, 32767));
                if ($urandom_range(1)) v[a] = -v[a];
                if ($urandom_range(1)) v[3 + b] = -v[3 + b];
            end
            default: begin
                amp = t_cos'($urandom_range(1, 32767));
                for (int i = 0; i < 6; i++) begin
                    case ($urandom_range(2))
                        0: v[i] = amp;
                        1: v[i] = -amp;
                        default: v[i] = CosZero;
                    endcase
                end
            end
        endcase
        set_orientation(v[0], v[1], v[2], v[3], v[4], v[5], $urandom_range(3) == 0);
    endtask

    task automatic test_random_orientations(input int phases);
        int words;
        for (int p = 0; p < phases; p++) begin
            load_random_orientation();
            gap_on   = $urandom_range(3) != 0;
            stall_on = $urandom_range(3) != 0;
            words    = $urandom_range(38, 52);
            for (int k = 0; k < words; k++) begin
                if (p == phases / 2 && k == words / 2) drain();
                send_word(rand_coord(), rand_coord(), rand_coord(),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_if.ready <= 1'b1;
            stall_left   <= pick_gap(stall_on);
        end
    end

    always @(posedge i_clk) begin : check_word
        t_xyz want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending.size() == 0) begin
                $error("unexpected word: x %0d y %0d z %0d", $signed(out_if.out_x),
                       $signed(out_if.out_y), $signed(out_if.out_z));
                errors++;
            end else begin
                want = pending.pop_front();
                compare_field("out_x", want.x, out_if.out_x);
                compare_field("out_y", want.y, out_if.out_y);
                compare_field("out_z", want.z, out_if.out_z);
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial begin : watchdog
        wait (quiet >= QuietLimit);
        $display("axis_snap_reorient_unit verification failed");
        $finish;
    end

    initial begin
        in_if.valid         = 1'b0;
        in_if.coord_x       = '0;
        in_if.coord_y       = '0;
        in_if.coord_z       = '0;
        in_if.make_absolute = 1'b0;
        in_if.inverse       = 1'b0;
        out_if.ready        = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = RegRowX;
        i_cfg_data          = '0;
        i_rst_n             = 1'b0;
        row_dir             = '{CosOne, CosZero, CosZero};
        col_dir             = '{CosZero, CosOne, CosZero};
        refresh_map();
        gap_on   = 1'b1;
        stall_on = 1'b1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_orientation();
        test_swapped_negated_axes();
        test_first_max_ties();
        test_zero_cosines();
        test_taken_column_skip();
        test_unused_index();
        test_random_orientations(12);

        drain();
        repeat (DrainCycles) @(posedge i_clk);

        $display("checked %0d words: %0d forward (%0d with absolute value), %0d inverse",
                 n_checked, n_fwd, n_abs, n_inv);
        $display("%0d orientations loaded: full-scale, tied, zero and near-axis cosines",
                 n_orient);
        if (errors == 0 && pending.size() == 0)
            $display("axis_snap_reorient_unit verification clean");
        else
            $display("axis_snap_reorient_unit verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/asr_pkg.sv
rtl/asr_in_if.sv
rtl/asr_out_if.sv
rtl/asr_snap.sv
rtl/asr_map.sv
rtl/axis_snap_reorient_unit.sv
sim/tb_axis_snap_reorient_unit.sv
